// File: sv/spd_pkg.sv
// ----------------------------------------------------------------------------
// spd_pkg
// Shared constants, codes and types of the plain SSH packet deframer.
// ----------------------------------------------------------------------------
package spd_pkg;

    // Width of the byte index inside one packet.
    localparam int INDEX_BITS     = 19;
    localparam int LEN_BITS       = 32;
    localparam int MIN_LEN_BITS   = 8;
    localparam int MAX_LEN_BITS   = 19;
    localparam int TIMEOUT_BITS   = 32;
    localparam int COUNT_BITS     = 32;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 2;
    localparam int HDR_BYTES      = 4;

    // Largest length field that the byte index can walk through.
    localparam logic [LEN_BITS-1:0] INDEX_MAX =
        LEN_BITS'((64'd1 << INDEX_BITS) - 64'd1);

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_TOTAL = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_TOTAL = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TIMEOUT   = 2'd2;

    // Configuration reset values.
    localparam logic [MIN_LEN_BITS-1:0] MIN_TOTAL_RESET = 8'd8;
    localparam logic [MAX_LEN_BITS-1:0] MAX_TOTAL_RESET = 19'd35000;
    localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET   = 32'd10000;

    // Input operations.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_LENGTH  = 2'd0;
    localparam logic [1:0] KIND_PADLEN  = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_PADDING = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_BUSY    = 3'd0;
    localparam logic [2:0] ST_OK      = 3'd1;
    localparam logic [2:0] ST_DISC    = 3'd2;
    localparam logic [2:0] ST_IGN     = 3'd3;
    localparam logic [2:0] ST_LENERR  = 3'd4;
    localparam logic [2:0] ST_PADERR  = 3'd5;
    localparam logic [2:0] ST_TIMEOUT = 3'd6;

    // SSH message numbers that get a status of their own.
    localparam logic [7:0] MSG_DISCONNECT = 8'd1;
    localparam logic [7:0] MSG_IGNORE     = 8'd2;
    localparam logic [7:0] MSG_DEBUG      = 8'd4;

    typedef struct packed {
        logic [MIN_LEN_BITS-1:0] min_total_length;
        logic [MAX_LEN_BITS-1:0] max_total_length;
        logic [TIMEOUT_BITS-1:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [7:0]            out_byte;
        logic [1:0]            kind;
        logic                  last;
        logic [2:0]            status;
        logic [COUNT_BITS-1:0] packets_received;
    } result_t;

    // Status of a good packet from its first payload byte.
    function automatic logic [2:0] classify(input logic [7:0] msg);
        logic [2:0] st;
        if (msg == MSG_DISCONNECT) begin
            st = ST_DISC;
        end else if (msg == MSG_IGNORE || msg == MSG_DEBUG) begin
            st = ST_IGN;
        end else begin
            st = ST_OK;
        end
        return st;
    endfunction

endpackage

// File: sv/spd_cfg_regs.sv
// ----------------------------------------------------------------------------
// spd_cfg_regs
// Configuration registers of the deframer, written through a plain port.
// ----------------------------------------------------------------------------
module spd_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [spd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [spd_pkg::CFG_DATA_BITS-1:0]   cfg_wr_data,
    output spd_pkg::cfg_t                       cfg
);

    spd_pkg::cfg_t cfg_reg;
    spd_pkg::cfg_t cfg_next;

    // The length registers keep only the low bits of the written word; the timeout register keeps all of it.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                spd_pkg::REG_MIN_TOTAL: begin
                    cfg_next.min_total_length = cfg_wr_data[spd_pkg::MIN_LEN_BITS-1:0];
                end
                spd_pkg::REG_MAX_TOTAL: begin
                    cfg_next.max_total_length = cfg_wr_data[spd_pkg::MAX_LEN_BITS-1:0];
                end
                spd_pkg::REG_TIMEOUT: begin
                    cfg_next.timeout_ticks = cfg_wr_data[spd_pkg::TIMEOUT_BITS-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_total_length <= spd_pkg::MIN_TOTAL_RESET;
            cfg_reg.max_total_length <= spd_pkg::MAX_TOTAL_RESET;
            cfg_reg.timeout_ticks    <= spd_pkg::TIMEOUT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: sv/spd_core.sv
// ----------------------------------------------------------------------------
// spd_core
// Packet framing state and the single-pass logic that turns one byte or
// tick into zero or one result.
// ----------------------------------------------------------------------------
module spd_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  spd_pkg::cfg_t     cfg,
    input  logic              item_valid,
    input  spd_pkg::item_t    item,
    output logic              res_valid,
    output spd_pkg::result_t  res
);

    localparam logic [1:0] PH_LENGTH = 2'd0;
    localparam logic [1:0] PH_PADLEN = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;

    localparam int IB = spd_pkg::INDEX_BITS;

    logic [1:0]                      phase_reg,    phase_next;
    logic [IB-1:0]                   idx_reg,      idx_next;
    logic [spd_pkg::LEN_BITS-1:0]    len_reg,      len_next;
    logic                            pad_err_reg,  pad_err_next;
    logic [IB-1:0]                   last_idx_reg, last_idx_next;
    logic [IB-1:0]                   payload_reg,  payload_next;
    logic [7:0]                      msg_reg,      msg_next;
    logic [spd_pkg::TIMEOUT_BITS-1:0] tick_reg,    tick_next;
    logic [spd_pkg::COUNT_BITS-1:0]  seq_reg,      seq_next;

    logic [spd_pkg::LEN_BITS-1:0]    len_shift;
    logic [spd_pkg::LEN_BITS:0]      total;
    logic [IB-1:0]                   idx_inc;
    logic                            len_err;
    logic [IB-1:0]                   len_idx;
    logic [IB-1:0]                   body;
    logic [IB-1:0]                   pad_ext;
    logic                            pad_err_now;
    logic [7:0]                      msg_now;
    logic [spd_pkg::TIMEOUT_BITS-1:0] tick_sat;
    logic                            good;
    logic                            restart;

    // Length collection: shift in the byte, check the finished field.
    assign len_shift = {len_reg[spd_pkg::LEN_BITS-9:0], item.rx_byte};
    assign total     = {1'b0, len_shift} + (spd_pkg::LEN_BITS+1)'(spd_pkg::HDR_BYTES);
    assign idx_inc   = idx_reg + IB'(1);
    assign len_err   = (len_shift == '0) || (len_shift > spd_pkg::INDEX_MAX) ||
                       (total < (spd_pkg::LEN_BITS+1)'(cfg.min_total_length)) ||
                       (total > (spd_pkg::LEN_BITS+1)'(cfg.max_total_length));

    // Padding-length byte: body bounds are worked out once, here.
    assign len_idx     = len_reg[IB-1:0];
    assign body        = len_idx - IB'(1);
    assign pad_ext     = IB'(item.rx_byte);
    assign pad_err_now = spd_pkg::LEN_BITS'(item.rx_byte) > len_reg;

    assign msg_now  = (idx_reg == '0) ? item.rx_byte : msg_reg;
    assign tick_sat = (tick_reg == '1) ? tick_reg : tick_reg + spd_pkg::TIMEOUT_BITS'(1);

    always_comb begin
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        len_next      = len_reg;
        pad_err_next  = pad_err_reg;
        last_idx_next = last_idx_reg;
        payload_next  = payload_reg;
        msg_next      = msg_reg;
        tick_next     = tick_reg;
        seq_next      = seq_reg;
        good          = 1'b0;
        restart       = 1'b0;
        res_valid     = 1'b0;
        res.out_byte  = item.rx_byte;
        res.kind      = spd_pkg::KIND_LENGTH;
        res.last      = 1'b0;
        res.status    = spd_pkg::ST_BUSY;

        if (item.op == spd_pkg::OP_TICK) begin
            tick_next = tick_sat;
            if (tick_sat >= cfg.timeout_ticks) begin
                res_valid    = 1'b1;
                res.out_byte = 8'd0;
                res.last     = 1'b1;
                res.status   = spd_pkg::ST_TIMEOUT;
                restart      = 1'b1;
            end
        end else begin
            res_valid = 1'b1;
            unique case (phase_reg)
                PH_PADLEN: begin
                    res.kind      = spd_pkg::KIND_PADLEN;
                    pad_err_next  = pad_err_now;
                    last_idx_next = len_idx - IB'(2);
                    payload_next  = (body > pad_ext) ? body - pad_ext : '0;
                    if (len_reg == spd_pkg::LEN_BITS'(1)) begin
                        // No body at all: the packet ends here, as a normal one unless the padding length is too large.
                        res.last   = 1'b1;
                        res.status = pad_err_now ? spd_pkg::ST_PADERR : spd_pkg::ST_OK;
                        good       = !pad_err_now;
                    end else begin
                        phase_next = PH_BODY;
                        idx_next   = '0;
                    end
                end
                PH_BODY: begin
                    res.kind = (idx_reg < payload_reg) ? spd_pkg::KIND_PAYLOAD
                                                       : spd_pkg::KIND_PADDING;
                    msg_next = msg_now;
                    if (idx_reg == last_idx_reg) begin
                        res.last   = 1'b1;
                        res.status = pad_err_reg ? spd_pkg::ST_PADERR
                                                 : spd_pkg::classify(msg_now);
                        good       = !pad_err_reg;
                    end else begin
                        idx_next = idx_inc;
                    end
                end
                default: begin
                    len_next = len_shift;
                    idx_next = idx_inc;
                    if (idx_inc >= IB'(spd_pkg::HDR_BYTES)) begin
                        if (len_err) begin
                            res.last   = 1'b1;
                            res.status = spd_pkg::ST_LENERR;
                        end else begin
                            phase_next = PH_PADLEN;
                            idx_next   = '0;
                        end
                    end
                end
            endcase
            restart = res.last;
        end

        if (good) begin
            seq_next = seq_reg + spd_pkg::COUNT_BITS'(1);
        end
        if (restart) begin
            phase_next = PH_LENGTH;
            idx_next   = '0;
            len_next   = '0;
            msg_next   = '0;
            tick_next  = '0;
        end
        res.packets_received = seq_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LENGTH;
            idx_reg   <= '0;
            len_reg   <= '0;
            msg_reg   <= '0;
            tick_reg  <= '0;
            seq_reg   <= '0;
        end else if (item_valid) begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
            msg_reg   <= msg_next;
            tick_reg  <= tick_next;
            seq_reg   <= seq_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_valid) begin
            pad_err_reg  <= pad_err_next;
            last_idx_reg <= last_idx_next;
            payload_reg  <= payload_next;
        end
    end

    // Every ending result leaves the framer ready for a new length field.
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid && res_valid && res.last |=>
            phase_reg == PH_LENGTH && idx_reg == '0 && tick_reg == '0)
        else $error("framer did not restart after an ending result");

    // The good-packet counter moves by one on each good ending only.
    a_count_good: assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid && res_valid && res.last &&
        (res.status == spd_pkg::ST_OK || res.status == spd_pkg::ST_DISC ||
         res.status == spd_pkg::ST_IGN) |=> seq_reg == $past(seq_reg) + 32'd1)
        else $error("packet counter missed a good packet");

    a_count_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !item_valid |=> $stable(seq_reg))
        else $error("packet counter moved without a transaction");

    // The body index never runs past the last body byte.
    a_body_index: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_BODY |-> idx_reg <= last_idx_reg)
        else $error("body index beyond packet end");

endmodule

// File: sv/ssh_plain_packet_deframer.sv
// ----------------------------------------------------------------------------
// ssh_plain_packet_deframer
// Pipeline: an accepted transaction waits in the input register, passes the
//   framing logic and leaves on the result channel from the result register.
// Throughput: one input transaction per cycle while the result channel is not
//   stalled, set by the single pass from the input register to the result register.
// Reset: synchronous, active-low aresetn clears the framing state, the tick
//   count and the packet counter and loads the register defaults at once.
// ----------------------------------------------------------------------------
module ssh_plain_packet_deframer (
    input  logic                                aclk,
    input  logic                                aresetn,

    // Configuration write port.
    input  logic                                cfg_wr_en,
    input  logic [spd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [spd_pkg::CFG_DATA_BITS-1:0]   cfg_wr_data,

    // Input channel: received bytes and timer ticks.
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_op,
    input  logic [7:0]                          s_rx_byte,

    // Result channel.
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [7:0]                          m_out_byte,
    output logic [1:0]                          m_kind,
    output logic                                m_last,
    output logic [2:0]                          m_status,
    output logic [spd_pkg::COUNT_BITS-1:0]      m_packets_received
);

    spd_pkg::cfg_t    cfg;
    spd_pkg::item_t   in_item_reg;
    logic             in_vld_reg;
    logic             in_vld_next;
    spd_pkg::result_t out_res_reg;
    logic             out_vld_reg;
    logic             out_vld_next;
    spd_pkg::result_t core_res;
    logic             core_res_valid;
    logic             fire;

    spd_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    // The held item is processed when the result register is free or is
    // being emptied in the same cycle. A tick that causes no result still
    // advances, so it never blocks the pipe.
    assign fire    = in_vld_reg && (!out_vld_reg || m_ready);

    // The input register takes a new transaction whenever it is empty or
    // its current item moves on in this cycle.
    assign s_ready = !in_vld_reg || fire;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
        end else if (fire) begin
            in_vld_next = 1'b0;
        end
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        if (fire) begin
            out_vld_next = core_res_valid;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    spd_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (fire),
        .item       (in_item_reg),
        .res_valid  (core_res_valid),
        .res        (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers load without reset; the valid flags guard them.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.op      <= s_op;
            in_item_reg.rx_byte <= s_rx_byte;
        end
        if (fire && core_res_valid) begin
            out_res_reg <= core_res;
        end
    end

    assign m_valid            = out_vld_reg;
    assign m_out_byte         = out_res_reg.out_byte;
    assign m_kind             = out_res_reg.kind;
    assign m_last             = out_res_reg.last;
    assign m_status           = out_res_reg.status;
    assign m_packets_received = out_res_reg.packets_received;

    // An accepted transaction is always captured in the input register.
    a_in_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> in_vld_reg)
        else $error("accepted transaction was not captured");

    // A held item waits unchanged while the result register is blocked.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && out_vld_reg && !m_ready |=>
            in_vld_reg && $stable(in_item_reg))
        else $error("held item lost while the result channel stalled");

    // A timeout result carries no byte and always ends the packet.
    a_timeout_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == spd_pkg::ST_TIMEOUT |->
            m_last && m_out_byte == 8'd0 && m_kind == spd_pkg::KIND_LENGTH)
        else $error("malformed timeout result");

endmodule
